/* hdl/pspt_pkg.sv */
// Shared types, sizes and operation codes for the paged slot presence table.
// No dependencies; imported by pspt_ctrl, pspt_dp and the top level.
package pspt_pkg;

	localparam int SLOTS_PER_BLOCK = 64;
	localparam int BLOCK_COUNT     = 64;

	localparam int ID_W     = 12;
	localparam int FUNC_W   = 3;
	localparam int NUM_W    = 6;
	localparam int TOT_W    = 13;
	localparam int CNTO_W   = 7;
	localparam int ID_MAX   = (1 << ID_W) - 1;

	localparam int SLOT_W   = $clog2(SLOTS_PER_BLOCK);
	localparam int BLK_W    = $clog2((ID_MAX / SLOTS_PER_BLOCK) + 1);
	localparam int ADDR_W   = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
	localparam int CNT_W    = $clog2(SLOTS_PER_BLOCK + 1);

	// Reciprocal for the block split: the estimate is low by at most one.
	localparam int DIV_SH   = ID_W + SLOT_W;
	localparam int PROD_W   = ID_W + DIV_SH;
	localparam int RECIP    = (1 << DIV_SH) / SLOTS_PER_BLOCK;

	localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_ENABLE  = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_DISABLE = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_QUERY   = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_FIND    = 3'd5;

	typedef struct packed {
		logic                       present;
		logic [SLOTS_PER_BLOCK-1:0] exists;
		logic [SLOTS_PER_BLOCK-1:0] enabled;
		logic [CNT_W-1:0]           elem_cnt;
		logic [CNT_W-1:0]           en_cnt;
	} row_t;

	localparam int ROW_W = $bits(row_t);

	typedef struct packed {
		logic clr_en;
		logic capture;
		logic div_en;
		logic fix_en;
		logic rd_en;
		logic exec_en;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
	} status_t;

endpackage

/* hdl/pspt_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pspt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hdl/pspt_ctrl.sv */
// Sequencer for the table: clearing pass after reset, then one operation at a time.
// Depends on pspt_pkg for the command and status structs.
module pspt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  pspt_pkg::status_t status,
	output pspt_pkg::cmd_t    cmd,
	output logic             busy
);
	import pspt_pkg::*;

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_DIV   = 3'd2;
	localparam logic [2:0] ST_FIX   = 3'd3;
	localparam logic [2:0] ST_RD    = 3'd4;
	localparam logic [2:0] ST_EXEC  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_en = 1'b1;
				state_d    = ST_FIX;
			end
			ST_FIX: begin
				cmd.fix_en = 1'b1;
				state_d    = ST_RD;
			end
			ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_EXEC;
			end
			ST_EXEC: begin
				cmd.exec_en = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

/* hdl/pspt_dp.sv */
// Datapath: id split, row read-modify-write, counters, find-next and result registers.
// Depends on pspt_pkg and pspt_ram.
module pspt_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  pspt_pkg::cmd_t               cmd,
	output pspt_pkg::status_t            status,
	input  logic [pspt_pkg::FUNC_W-1:0]  func,
	input  logic [pspt_pkg::ID_W-1:0]    elem_id,
	output logic                         done,
	output logic                         slot_exists,
	output logic                         slot_enabled,
	output logic                         block_is_present,
	output logic [pspt_pkg::NUM_W-1:0]   block_number,
	output logic [pspt_pkg::NUM_W-1:0]   slot_offset,
	output logic [pspt_pkg::TOT_W-1:0]   total_elements,
	output logic [pspt_pkg::CNTO_W-1:0]  block_elements,
	output logic [pspt_pkg::CNTO_W-1:0]  block_enabled,
	output logic                         next_found,
	output logic [pspt_pkg::ID_W-1:0]    next_id
);
	import pspt_pkg::*;

	localparam int S = SLOTS_PER_BLOCK;

	logic [FUNC_W-1:0] func_q;
	logic [ID_W-1:0]   id_q;
	logic [BLK_W-1:0]  q_est_q;
	logic [BLK_W-1:0]  blk_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ID_W-1:0]   base_q;
	logic [ADDR_W-1:0] clr_q;
	logic [TOT_W-1:0]  total_q;

	// Operand capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			id_q   <= elem_id;
		end
	end

	// Block estimate by reciprocal multiply
	logic [PROD_W-1:0] prod;
	assign prod = PROD_W'(id_q) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		if (cmd.div_en) begin
			q_est_q <= prod[DIV_SH +: BLK_W];
		end
	end

	// Correct the estimate by at most one block
	logic [ID_W-1:0] base_est;
	logic [ID_W-1:0] rem_est;
	logic            rem_over;
	assign base_est = ID_W'(q_est_q) * ID_W'(S);
	assign rem_est  = id_q - base_est;
	assign rem_over = (rem_est >= ID_W'(S));

	always_ff @(posedge clk) begin
		if (cmd.fix_en) begin
			if (rem_over) begin
				blk_q  <= q_est_q + BLK_W'(1);
				slot_q <= SLOT_W'(rem_est - ID_W'(S));
				base_q <= base_est + ID_W'(S);
			end else begin
				blk_q  <= q_est_q;
				slot_q <= SLOT_W'(rem_est);
				base_q <= base_est;
			end
		end
	end

	logic [ID_W-1:0]   blk_ext;
	logic              in_range;
	logic [ADDR_W-1:0] blk_addr;
	assign blk_ext  = ID_W'(blk_q);
	assign in_range = (blk_ext < ID_W'(BLOCK_COUNT));
	assign blk_addr = blk_ext[ADDR_W-1:0];

	// Clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_en) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end
	assign status.clr_last = (clr_q == ADDR_W'(BLOCK_COUNT - 1));

	// Row store
	row_t              row_rd;
	row_t              row_wr;
	logic [ROW_W-1:0]  ram_rdata;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [ROW_W-1:0]  ram_wdata;

	assign row_rd    = row_t'(ram_rdata);
	assign ram_we    = cmd.clr_en || (cmd.exec_en && in_range);
	assign ram_waddr = cmd.clr_en ? clr_q : blk_addr;
	assign ram_wdata = cmd.clr_en ? '0 : ROW_W'(row_wr);

	pspt_ram #(
		.WIDTH (ROW_W),
		.DEPTH (BLOCK_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (blk_addr),
		.rdata (ram_rdata)
	);

	// Modify
	logic [S-1:0]      bit_sel;
	logic              ex;
	logic              en;
	logic [TOT_W-1:0]  total_d;
	logic [S-1:0]      masked;
	logic [S-1:0]      lowest;
	logic [SLOT_W-1:0] found_slot;
	logic              found;

	assign bit_sel = S'(1) << slot_q;
	assign ex      = |(row_rd.exists & bit_sel);
	assign en      = |(row_rd.enabled & bit_sel);

	always_comb begin
		row_wr  = row_rd;
		total_d = total_q;
		unique case (func_q)
			FUNC_ALLOC: begin
				row_wr.present = 1'b1;
				if (!ex) begin
					total_d         = total_q + TOT_W'(1);
					row_wr.elem_cnt = row_rd.elem_cnt + CNT_W'(1);
					row_wr.en_cnt   = row_rd.en_cnt + CNT_W'(1);
				end else if (!en) begin
					row_wr.en_cnt   = row_rd.en_cnt + CNT_W'(1);
				end
				row_wr.exists  = row_rd.exists | bit_sel;
				row_wr.enabled = row_rd.enabled | bit_sel;
			end
			FUNC_REMOVE: begin
				if (row_rd.present && ex) begin
					total_d         = total_q - TOT_W'(1);
					row_wr.elem_cnt = row_rd.elem_cnt - CNT_W'(1);
					if (en) begin
						row_wr.en_cnt = row_rd.en_cnt - CNT_W'(1);
					end
					row_wr.exists  = row_rd.exists & ~bit_sel;
					row_wr.enabled = row_rd.enabled & ~bit_sel;
				end
			end
			FUNC_ENABLE: begin
				if (row_rd.present && ex && !en) begin
					row_wr.enabled = row_rd.enabled | bit_sel;
					row_wr.en_cnt  = row_rd.en_cnt + CNT_W'(1);
				end
			end
			FUNC_DISABLE: begin
				if (row_rd.present && ex && en) begin
					row_wr.enabled = row_rd.enabled & ~bit_sel;
					row_wr.en_cnt  = row_rd.en_cnt - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Find-next: keep slots at or above the addressed one, isolate the lowest set bit
	assign masked = row_rd.exists & ~(bit_sel - S'(1));
	assign lowest = masked & (~masked + S'(1));
	assign found  = row_rd.present && (func_q == FUNC_FIND) && (|masked);

	always_comb begin
		found_slot = '0;
		for (int i = 0; i < S; i++) begin
			if (lowest[i]) begin
				found_slot = found_slot | SLOT_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			done    <= 1'b0;
		end else begin
			done <= cmd.exec_en;
			if (cmd.exec_en && in_range) begin
				total_q <= total_d;
			end
		end
	end

	// Result beat
	logic [ID_W-1:0] slot_ext;
	assign slot_ext = ID_W'(slot_q);

	always_ff @(posedge clk) begin
		if (cmd.exec_en) begin
			block_number   <= blk_ext[NUM_W-1:0];
			slot_offset    <= slot_ext[NUM_W-1:0];
			total_elements <= in_range ? total_d : total_q;
			next_found     <= in_range && found;
			next_id        <= (in_range && found) ? base_q + ID_W'(found_slot) : '0;
			if (in_range) begin
				slot_exists      <= |(row_wr.exists & bit_sel);
				slot_enabled     <= |(row_wr.enabled & bit_sel);
				block_is_present <= row_wr.present;
				block_elements   <= CNTO_W'(row_wr.elem_cnt);
				block_enabled    <= CNTO_W'(row_wr.en_cnt);
			end else begin
				slot_exists      <= 1'b0;
				slot_enabled     <= 1'b0;
				block_is_present <= 1'b0;
				block_elements   <= '0;
				block_enabled    <= '0;
			end
		end
	end

endmodule

/* hdl/paged_slot_presence_table.sv */
// Paged slot presence table, top level: joins the sequencer and the datapath.
// Depends on pspt_pkg, pspt_ctrl, pspt_dp (and pspt_ram through the datapath).
//
// Usage:
//   Command channel: drive func and elem_id with start high; the beat is taken
//   at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle with all result fields;
//   the receiver cannot stall, so the beat is taken at the end of that cycle.
// Timing:
//   Each operation runs through the sequencer in order: operand capture,
//   reciprocal multiply for the block split, remainder correction, row read
//   from the single block RAM, then read-modify-write of that row. done rises
//   at the same moment that busy drops, so a new command may be issued while
//   the result beat is shown. The block takes no new command until the
//   previous one is through; busy stays high for all of its steps.
// Reset:
//   arst_n clears the sequencer, the total count and the strobe at once; the
//   block then sweeps the RAM, one row a cycle, through all BLOCK_COUNT rows
//   (64 at the default size) with busy high before the first command is taken.
module paged_slot_presence_table (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [pspt_pkg::FUNC_W-1:0]  func,
	input  logic [pspt_pkg::ID_W-1:0]    elem_id,
	output logic                         done,
	output logic                         slot_exists,
	output logic                         slot_enabled,
	output logic                         block_is_present,
	output logic [pspt_pkg::NUM_W-1:0]   block_number,
	output logic [pspt_pkg::NUM_W-1:0]   slot_offset,
	output logic [pspt_pkg::TOT_W-1:0]   total_elements,
	output logic [pspt_pkg::CNTO_W-1:0]  block_elements,
	output logic [pspt_pkg::CNTO_W-1:0]  block_enabled,
	output logic                         next_found,
	output logic [pspt_pkg::ID_W-1:0]    next_id
);
	import pspt_pkg::*;

	cmd_t    cmd;
	status_t status;

	pspt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	pspt_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.status           (status),
		.func             (func),
		.elem_id          (elem_id),
		.done             (done),
		.slot_exists      (slot_exists),
		.slot_enabled     (slot_enabled),
		.block_is_present (block_is_present),
		.block_number     (block_number),
		.slot_offset      (slot_offset),
		.total_elements   (total_elements),
		.block_elements   (block_elements),
		.block_enabled    (block_enabled),
		.next_found       (next_found),
		.next_id          (next_id)
	);

endmodule
